FILE: hw/rtl/rob_pkg.sv
// ----------------------------------------------------------------------------
// rob_pkg
// Shared types and constants for the in-order reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rob_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SEQ_W       = 32;
	localparam int DATA_W      = 32;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DELIVERED = 2'd0,
		KIND_QUEUED    = 2'd1,
		KIND_DROPPED   = 2'd2
	} kind_t;

	// priority tokens passed from one cell to the next
	typedef struct packed {
		logic free_seen;   // a free slot lies at a lower index
		logic hi_seen;     // a hit at or above the search start lies lower
		logic all_seen;    // any hit lies lower
	} chain_t;

	// slot commands from the controller
	typedef struct packed {
		logic wr;          // store request into the lowest free slot
		logic clr;         // free the selected hit slot
	} slot_ctl_t;

	// search status returned to the controller
	typedef struct packed {
		logic              any_free;
		logic              hit_found;
		logic [IDX_W-1:0]  hit_idx;
		logic [SEQ_W-1:0]  hit_seq;
		logic [DATA_W-1:0] hit_data;
	} scan_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rob_cell.sv
// ----------------------------------------------------------------------------
// rob_cell
// One buffer slot: holds a request, compares it to the expected number and
// passes free/hit priority tokens on to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module rob_cell
	import rob_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slot_ctl_t         ctl,
	input  wire logic              sel,
	input  wire logic              in_window,
	input  wire logic [SEQ_W-1:0]  wr_seq,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [SEQ_W-1:0]  expected,
	input  wire chain_t            chain_i,
	output chain_t                 chain_o,
	output logic                   pick_hi,
	output logic                   pick_all,
	output logic [SEQ_W-1:0]       slot_seq,
	output logic [DATA_W-1:0]      slot_data
);

	logic              valid_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [DATA_W-1:0] data_q;
	logic              hit;
	logic              hit_hi;
	logic              pick_free;

	// match and priority tokens
	always_comb begin
		hit       = valid_q && (seq_q == expected);
		hit_hi    = hit && in_window;
		pick_free = !valid_q && !chain_i.free_seen;
		pick_hi   = hit_hi && !chain_i.hi_seen;
		pick_all  = hit && !chain_i.all_seen;
		chain_o.free_seen = chain_i.free_seen || !valid_q;
		chain_o.hi_seen   = chain_i.hi_seen || hit_hi;
		chain_o.all_seen  = chain_i.all_seen || hit;
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.wr && pick_free) begin
			valid_q <= 1'b1;
		end else if (ctl.clr && sel) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.wr && pick_free) begin
			seq_q  <= wr_seq;
			data_q <= wr_data;
		end
	end

	assign slot_seq  = seq_q;
	assign slot_data = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rob_chain.sv
// ----------------------------------------------------------------------------
// rob_chain
// Row of slot cells with a circular search window and the readout of the
// selected hit.
// ----------------------------------------------------------------------------
`default_nettype none

module rob_chain
	import rob_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slot_ctl_t         ctl,
	input  wire logic [SEQ_W-1:0]  wr_seq,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [SEQ_W-1:0]  expected,
	input  wire logic [IDX_W-1:0]  start,
	output scan_t                  scan
);

	chain_t                  link [QUEUE_DEPTH+1];
	logic [QUEUE_DEPTH-1:0]  sel;
	logic [QUEUE_DEPTH-1:0]  pick_hi;
	logic [QUEUE_DEPTH-1:0]  pick_all;
	logic [SEQ_W-1:0]        cell_seq  [QUEUE_DEPTH];
	logic [DATA_W-1:0]       cell_data [QUEUE_DEPTH];
	logic                    any_hi;

	assign link[0] = '0;
	assign any_hi  = link[QUEUE_DEPTH].hi_seen;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		// first pass covers slots at or after the start point, wrap pass all
		assign sel[i] = any_hi ? pick_hi[i] : pick_all[i];

		rob_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel       (sel[i]),
			.in_window (IDX_W'(i) >= start),
			.wr_seq    (wr_seq),
			.wr_data   (wr_data),
			.expected  (expected),
			.chain_i   (link[i]),
			.chain_o   (link[i+1]),
			.pick_hi   (pick_hi[i]),
			.pick_all  (pick_all[i]),
			.slot_seq  (cell_seq[i]),
			.slot_data (cell_data[i])
		);
	end

	// one-hot readout of the selected slot
	always_comb begin
		scan.any_free  = link[QUEUE_DEPTH].free_seen;
		scan.hit_found = link[QUEUE_DEPTH].all_seen;
		scan.hit_idx   = '0;
		scan.hit_seq   = '0;
		scan.hit_data  = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (sel[i]) begin
				scan.hit_idx  = scan.hit_idx | IDX_W'(i);
				scan.hit_seq  = scan.hit_seq | cell_seq[i];
				scan.hit_data = scan.hit_data | cell_data[i];
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/in_order_reorder_buffer_top.sv
// ----------------------------------------------------------------------------
// in_order_reorder_buffer_top
// Delivers sequenced messages in order, parking early ones in a slot row.
// ----------------------------------------------------------------------------
// A message whose number is not the expected one is stored in the lowest free
// slot (or dropped when all slots are taken) and reported through the result
// register. A message carrying the expected number starts a delivery run: it
// is reported first, then each following number found in the slots is
// released, one per cycle while the receiver does not stall. A run steps
// through the accept, one search that hits per freed slot, and one search
// that misses and closes the run with last set; the input is stalled from
// the accept until the run closes, and while the receiver stalls a pending
// result. Each run step makes a single search across the cell row, compared
// in parallel against the expected number. The expected number starts at 1
// after reset and wraps modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module in_order_reorder_buffer_top
	import rob_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              msg_valid,
	output logic                   msg_stall,
	input  wire logic [SEQ_W-1:0]  msg_seq,
	input  wire logic [DATA_W-1:0] msg_data,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [1:0]             kind,
	output logic [SEQ_W-1:0]       out_seq,
	output logic [DATA_W-1:0]      out_data,
	output logic                   last
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	logic [SEQ_W-1:0]  expected_q;
	logic [IDX_W-1:0]  start_q;
	logic [SEQ_W-1:0]  hold_seq_q;
	logic [DATA_W-1:0] hold_data_q;
	logic              res_valid_q;
	kind_t             res_kind_q;
	logic [SEQ_W-1:0]  res_seq_q;
	logic [DATA_W-1:0] res_data_q;
	logic              res_last_q;

	logic              out_free;
	logic              take;
	logic              is_next;
	logic              res_push;
	slot_ctl_t         ctl;
	scan_t             scan;
	logic [IDX_W-1:0]  next_start;

	// handshake
	assign out_free  = !res_valid_q || !res_stall;
	assign msg_stall = (state_q != ST_IDLE) || !out_free;
	assign take      = msg_valid && !msg_stall;
	assign is_next   = (msg_seq == expected_q);

	// a result is loaded for a parked/dropped request or each run step
	assign res_push = ((state_q == ST_IDLE) && take && !is_next) ||
		((state_q == ST_RUN) && out_free);

	assign ctl.wr  = take && !is_next;
	assign ctl.clr = (state_q == ST_RUN) && out_free && scan.hit_found;

	// circular search resumes just after the slot released
	assign next_start = (scan.hit_idx == IDX_W'(QUEUE_DEPTH - 1)) ?
		'0 : scan.hit_idx + IDX_W'(1);

	rob_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.wr_seq   (msg_seq),
		.wr_data  (msg_data),
		.expected (expected_q),
		.start    (start_q),
		.scan     (scan)
	);

	// controller and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			expected_q  <= SEQ_W'(1);
			start_q     <= '0;
			hold_seq_q  <= '0;
			hold_data_q <= '0;
			res_valid_q <= 1'b0;
			res_kind_q  <= KIND_DELIVERED;
			res_seq_q   <= '0;
			res_data_q  <= '0;
			res_last_q  <= 1'b0;
		end else begin
			if (res_push) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (is_next) begin
							hold_seq_q  <= msg_seq;
							hold_data_q <= msg_data;
							expected_q  <= expected_q + SEQ_W'(1);
							start_q     <= '0;
							state_q     <= ST_RUN;
						end else begin
							res_kind_q  <= scan.any_free ? KIND_QUEUED : KIND_DROPPED;
							res_seq_q   <= msg_seq;
							res_data_q  <= msg_data;
							res_last_q  <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (out_free) begin
						// push the held delivery; last once the search misses
						res_kind_q  <= KIND_DELIVERED;
						res_seq_q   <= hold_seq_q;
						res_data_q  <= hold_data_q;
						res_last_q  <= !scan.hit_found;
						if (scan.hit_found) begin
							hold_seq_q  <= scan.hit_seq;
							hold_data_q <= scan.hit_data;
							expected_q  <= expected_q + SEQ_W'(1);
							start_q     <= next_start;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign kind      = res_kind_q;
	assign out_seq   = res_seq_q;
	assign out_data  = res_data_q;
	assign last      = res_last_q;

	// a run always closes with a result flagged last
	a_run_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == ST_RUN && state_q == ST_IDLE) |-> (res_valid_q && res_last_q))
		else $error("delivery run ended without a last result");

	// expected number only ever steps by one
	a_expected_step: assert property (@(posedge clk) disable iff (!arst_n)
		(expected_q != $past(expected_q)) |-> (expected_q == $past(expected_q) + SEQ_W'(1)))
		else $error("expected number jumped");

	// a slot is only released while a delivery is pushed to the output
	a_clear_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |=> (res_valid_q && res_kind_q == KIND_DELIVERED && !res_last_q))
		else $error("slot released without a delivered result");

endmodule

`default_nettype wire
